### rtl/core/pea_pkg.sv
`timescale 1ns / 1ps
package pea_pkg;

    localparam int PIX_W       = 12;
    localparam int DELTA_W     = 13;
    localparam int RAD_W       = 11;
    localparam int NUM_W       = 10;
    localparam int IDX_W       = 9;
    localparam int ELEV_W      = 15;
    localparam int AZ_W        = 17;
    localparam int STEPS       = 17;

    localparam logic [RAD_W-1:0] RAD_MIN   = 11'd30;
    localparam logic [RAD_W-1:0] RAD_MAX   = 11'd1800;
    localparam logic [RAD_W-1:0] RAD_RESET = 11'd180;
    localparam logic [ELEV_W-1:0] ELEV_FULL = 15'd23040;
    localparam logic signed [17:0] HALF_TURN = 18'sd46080;
    localparam logic [19:0] ELEV_K2 = 20'd826281;
    localparam logic signed [24:0] Z_QUARTER = 25'sd5898240;

    typedef struct packed {
        logic [NUM_W-1:0]   number;
        logic               far;
        logic               ax_zero;
        logic               ay_zero;
        logic               x_neg;
        logic               y_neg;
        logic [63:0]        tsq;
        logic [28:0]        msq;
        logic [63:0]        a2;
        logic [63:0]        b;
        logic [STEPS-1:0]   w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [24:0] z;
    } pea_iter_t;

    function automatic logic signed [24:0] atan_entry(input int i);
        case (i)
            0:       return 25'sd2949120;
            1:       return 25'sd1740967;
            2:       return 25'sd919879;
            3:       return 25'sd466945;
            4:       return 25'sd234379;
            5:       return 25'sd117304;
            6:       return 25'sd58666;
            7:       return 25'sd29335;
            8:       return 25'sd14668;
            9:       return 25'sd7334;
            10:      return 25'sd3667;
            11:      return 25'sd1833;
            12:      return 25'sd917;
            13:      return 25'sd458;
            14:      return 25'sd229;
            15:      return 25'sd115;
            16:      return 25'sd57;
            default: return 25'sd0;
        endcase
    endfunction

endpackage

### rtl/core/pea_step.sv
`timescale 1ns / 1ps
module pea_step #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  pea_pkg::pea_iter_t in_data,
    output logic              out_valid,
    output pea_pkg::pea_iter_t out_data
);

    localparam int K = pea_pkg::STEPS - 1 - STEP;

    logic               valid_reg;
    pea_pkg::pea_iter_t data_reg;
    pea_pkg::pea_iter_t data_next;
    logic [63:0]        trial;

    // One digit of the scaled distance and one vectoring rotation per stage.
    always_comb
    begin
        data_next = in_data;
        trial = in_data.a2 + (in_data.b << (K + 1)) + (64'(in_data.msq) << (2 * K));
        if (trial <= in_data.tsq)
        begin
            data_next.a2   = trial;
            data_next.b    = in_data.b + (64'(in_data.msq) << K);
            data_next.w[K] = 1'b1;
        end
        if (in_data.y > 32'sd0)
        begin
            data_next.x = in_data.x + (in_data.y >>> STEP);
            data_next.y = in_data.y - (in_data.x >>> STEP);
            data_next.z = in_data.z + pea_pkg::atan_entry(STEP);
        end
        else
        begin
            data_next.x = in_data.x - (in_data.y >>> STEP);
            data_next.y = in_data.y + (in_data.x >>> STEP);
            data_next.z = in_data.z - pea_pkg::atan_entry(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/pixel_to_elevation_azimuth_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake            Beat contents
// input     in_valid/in_ready    source_index, pixel_x, pixel_y
// output    out_valid/out_ready  source_number, elevation, azimuth
// config    cfg_we               cfg_wdata (radius)
//
// One beat is accepted per cycle while the output is not stalled. The path from input to
// result runs through four setup stages, the 17-stage distance-digit and vectoring
// pipeline and the output register.
// Reset clears all valid bits and loads a radius of 180.
// A stall at the output holds every stage in place.
module pixel_to_elevation_azimuth_unit #(
    parameter int MAX_SOURCES = 512,
    parameter int COORD_BITS  = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pea_pkg::RAD_W-1:0]       cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pea_pkg::IDX_W-1:0]       source_index,
    input  logic [pea_pkg::PIX_W-1:0]       pixel_x,
    input  logic [pea_pkg::PIX_W-1:0]       pixel_y,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pea_pkg::NUM_W-1:0]       source_number,
    output logic [pea_pkg::ELEV_W-1:0]      elevation,
    output logic signed [pea_pkg::AZ_W-1:0] azimuth
);

    localparam int USE_BITS = (COORD_BITS < pea_pkg::PIX_W) ? COORD_BITS : pea_pkg::PIX_W;
    localparam logic [pea_pkg::PIX_W-1:0] PIX_MASK = pea_pkg::PIX_W'((1 << USE_BITS) - 1);

    function automatic logic [pea_pkg::IDX_W-1:0] wrap_index(
        input logic [pea_pkg::IDX_W-1:0] v
    );
        int r;
        r = int'(v);
        for (int k = pea_pkg::IDX_W - 1; k >= 0; k--)
        begin
            if (r >= (MAX_SOURCES << k))
            begin
                r = r - (MAX_SOURCES << k);
            end
        end
        return r[pea_pkg::IDX_W-1:0];
    endfunction

    logic en;
    logic [pea_pkg::RAD_W-1:0] rad_reg;
    logic [pea_pkg::RAD_W-1:0] rad_eff;

    logic                                v1_reg;
    logic [pea_pkg::NUM_W-1:0]           num1_reg;
    logic signed [pea_pkg::DELTA_W-1:0]  dx1_reg, dy1_reg;
    logic [pea_pkg::RAD_W-1:0]           rad1_reg;
    logic signed [pea_pkg::DELTA_W-1:0]  dx1_next, dy1_next;

    logic                                v2_reg;
    logic [pea_pkg::NUM_W-1:0]           num2_reg;
    logic [23:0]                         dxsq2_reg, dysq2_reg;
    logic [21:0]                         radsq2_reg;
    logic [pea_pkg::PIX_W-1:0]           ax2_reg, ay2_reg;
    logic                                xneg2_reg, yneg2_reg;
    logic signed [25:0]                  dxsq_full, dysq_full;
    logic signed [pea_pkg::DELTA_W-1:0]  ax2_next, ay2_next;

    logic                                v3_reg;
    logic [pea_pkg::NUM_W-1:0]           num3_reg;
    logic [24:0]                         s3_reg;
    logic                                far3_reg;
    logic [28:0]                         msq3_reg;
    logic [pea_pkg::PIX_W-1:0]           ax3_reg, ay3_reg;
    logic                                xneg3_reg, yneg3_reg;
    logic [24:0]                         s3_next;

    logic                                stage0_vld_reg;
    pea_pkg::pea_iter_t                  stage0_data_reg;
    logic                                stage_vld [0:pea_pkg::STEPS];
    pea_pkg::pea_iter_t                  stage_data [0:pea_pkg::STEPS];
    logic [44:0]                         tsq_prod;

    logic                                out_valid_reg;
    logic [pea_pkg::NUM_W-1:0]           num_out_reg;
    logic [pea_pkg::ELEV_W-1:0]          elev_out_reg;
    logic signed [pea_pkg::AZ_W-1:0]     az_out_reg;
    logic [pea_pkg::ELEV_W-1:0]          elev_next;
    logic signed [pea_pkg::AZ_W-1:0]     az_next;
    logic signed [24:0]                  zc;
    logic [22:0]                         tz;
    logic [22:0]                         tr;
    logic signed [17:0]                  t_s;
    logic signed [17:0]                  az_wide;
    logic [17:0]                         w_inc;
    logic [pea_pkg::ELEV_W-1:0]          lo;

    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg <= pea_pkg::RAD_RESET;
        end
        else if (cfg_we)
        begin
            rad_reg <= cfg_wdata;
        end
    end

    assign rad_eff = (rad_reg < pea_pkg::RAD_MIN) ? pea_pkg::RAD_MIN :
                     (rad_reg > pea_pkg::RAD_MAX) ? pea_pkg::RAD_MAX : rad_reg;

    assign dx1_next = $signed({1'b0, pixel_x & PIX_MASK}) - $signed({2'b00, rad_eff});
    assign dy1_next = $signed({1'b0, pixel_y & PIX_MASK}) - $signed({2'b00, rad_eff});

    assign dxsq_full = dx1_reg * dx1_reg;
    assign dysq_full = dy1_reg * dy1_reg;
    assign ax2_next  = (dy1_reg < 0) ? -dy1_reg : dy1_reg;
    assign ay2_next  = (dx1_reg < 0) ? -dx1_reg : dx1_reg;

    assign s3_next  = {1'b0, dxsq2_reg} + {1'b0, dysq2_reg};
    assign tsq_prod = s3_reg * pea_pkg::ELEV_K2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            stage0_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg         <= in_valid;
            v2_reg         <= v1_reg;
            v3_reg         <= v2_reg;
            stage0_vld_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg  <= {1'b0, wrap_index(source_index)} + 10'd1;
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            rad1_reg  <= rad_eff;

            num2_reg   <= num1_reg;
            dxsq2_reg  <= dxsq_full[23:0];
            dysq2_reg  <= dysq_full[23:0];
            radsq2_reg <= rad1_reg * rad1_reg;
            ax2_reg    <= ax2_next[pea_pkg::PIX_W-1:0];
            ay2_reg    <= ay2_next[pea_pkg::PIX_W-1:0];
            xneg2_reg  <= dy1_reg > 0;
            yneg2_reg  <= dx1_reg > 0;

            num3_reg  <= num2_reg;
            s3_reg    <= s3_next;
            far3_reg  <= s3_next > {1'b0, radsq2_reg, 2'b00};
            msq3_reg  <= 29'(radsq2_reg * 7'd100);
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            xneg3_reg <= xneg2_reg;
            yneg3_reg <= yneg2_reg;

            stage0_data_reg.number  <= num3_reg;
            stage0_data_reg.far     <= far3_reg;
            stage0_data_reg.ax_zero <= ax3_reg == '0;
            stage0_data_reg.ay_zero <= ay3_reg == '0;
            stage0_data_reg.x_neg   <= xneg3_reg;
            stage0_data_reg.y_neg   <= yneg3_reg;
            stage0_data_reg.tsq     <= {1'b0, tsq_prod, 18'd0};
            stage0_data_reg.msq     <= msq3_reg;
            stage0_data_reg.a2      <= '0;
            stage0_data_reg.b       <= '0;
            stage0_data_reg.w       <= '0;
            stage0_data_reg.x       <= $signed({4'd0, ax3_reg, 16'd0});
            stage0_data_reg.y       <= $signed({4'd0, ay3_reg, 16'd0});
            stage0_data_reg.z       <= '0;
        end
    end

    assign stage_vld[0]  = stage0_vld_reg;
    assign stage_data[0] = stage0_data_reg;

    for (genvar j = 0; j < pea_pkg::STEPS; j++)
    begin : g_step
        pea_step #(
            .STEP(j)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (stage_vld[j]),
            .in_data  (stage_data[j]),
            .out_valid(stage_vld[j+1]),
            .out_data (stage_data[j+1])
        );
    end

    always_comb
    begin
        if (stage_data[pea_pkg::STEPS].ay_zero)
        begin
            zc = '0;
        end
        else if (stage_data[pea_pkg::STEPS].ax_zero)
        begin
            zc = pea_pkg::Z_QUARTER;
        end
        else if (stage_data[pea_pkg::STEPS].z < 0)
        begin
            zc = '0;
        end
        else if (stage_data[pea_pkg::STEPS].z > pea_pkg::Z_QUARTER)
        begin
            zc = pea_pkg::Z_QUARTER;
        end
        else
        begin
            zc = stage_data[pea_pkg::STEPS].z;
        end
        tz  = zc[22:0];
        tr  = (tz + 23'd128) >> 8;
        t_s = $signed({3'd0, tr[14:0]});
        case ({stage_data[pea_pkg::STEPS].x_neg, stage_data[pea_pkg::STEPS].y_neg})
            2'b00:   az_wide = t_s;
            2'b10:   az_wide = pea_pkg::HALF_TURN - t_s;
            2'b11:   az_wide = t_s - pea_pkg::HALF_TURN;
            default: az_wide = -t_s;
        endcase
        if (az_wide >= pea_pkg::HALF_TURN)
        begin
            az_wide = -pea_pkg::HALF_TURN;
        end
        az_next = az_wide[pea_pkg::AZ_W-1:0];

        w_inc = ({1'b0, stage_data[pea_pkg::STEPS].w} + 18'd1) >> 1;
        lo = (w_inc > {3'd0, pea_pkg::ELEV_FULL}) ? pea_pkg::ELEV_FULL : w_inc[14:0];
        elev_next = stage_data[pea_pkg::STEPS].far ? '0 : pea_pkg::ELEV_FULL - lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stage_vld[pea_pkg::STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_out_reg  <= stage_data[pea_pkg::STEPS].number;
            elev_out_reg <= elev_next;
            az_out_reg   <= az_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign source_number = num_out_reg;
    assign elevation     = elev_out_reg;
    assign azimuth       = az_out_reg;

endmodule

### rtl/core/pea_checker.sv
`timescale 1ns / 1ps
module pea_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [pea_pkg::NUM_W-1:0]       source_number,
    input logic [pea_pkg::ELEV_W-1:0]      elevation,
    input logic signed [pea_pkg::AZ_W-1:0] azimuth
);

    // A stalled result beat holds its elevation and azimuth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(elevation) && $stable(azimuth))
    else $error("stalled result beat changed");

    // A stalled output freezes the pipeline, so no new beat enters.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> elevation <= pea_pkg::ELEV_FULL && source_number != '0)
    else $error("elevation or source number out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> azimuth >= -17'sd46080 && azimuth <= 17'sd46079)
    else $error("azimuth out of range");

endmodule

bind pixel_to_elevation_azimuth_unit pea_checker u_pea_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .source_number(source_number),
    .elevation    (elevation),
    .azimuth      (azimuth)
);
